[sv/brem_pkg.sv]
// Package for the band RMS energy meter: beat types, control struct and constants.
`default_nettype none
package brem_pkg;

    localparam int unsigned NUM_BANDS_DEF = 32;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SPB_W    = 13;
    localparam int unsigned SQ_W     = 31;
    localparam int unsigned SUM_W    = 43;
    localparam int unsigned QUO_W    = 31;
    localparam int unsigned RMS_W    = 16;
    localparam int unsigned ENERGY_W = 16;
    localparam int unsigned COEF_W   = 16;

    localparam logic [SPB_W-1:0]  SPB_RESET = SPB_W'(16);
    localparam logic [SPB_W-1:0]  SPB_MAX   = SPB_W'(4096);
    localparam logic [COEF_W-1:0] C_OLD     = COEF_W'(51117);
    localparam logic [COEF_W-1:0] C_NEW     = COEF_W'(14418);

    // APB register map.
    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_SPB = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]          band_index;
        logic [ENERGY_W-1:0] band_energy;
        logic                last_band;
    } t_out_beat;

    // Commands from the sequencer to the energy store.
    typedef struct packed {
        logic rd;
        logic mul;
        logic wr;
    } t_store_ctl;

endpackage
`default_nettype wire

[sv/brem_div.sv]
// Restoring divider: one quotient bit per cycle, band square sum by band length.
`default_nettype none
module brem_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [brem_pkg::SUM_W-1:0]  i_dividend,
    input  wire logic [brem_pkg::SPB_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [brem_pkg::QUO_W-1:0]       o_quot
);
    import brem_pkg::*;

    localparam int unsigned CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [SPB_W-1:0] r_rem;

    logic [SPB_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_q[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_rem <= ge ? SPB_W'(rem_sh - {1'b0, i_divisor}) : rem_sh[SPB_W-1:0];
        end
    end

    assign o_done = r_done;
    // The mean of squares never exceeds one full-scale square, so the upper bits are zero.
    assign o_quot = r_q[QUO_W-1:0];

endmodule
`default_nettype wire

[sv/brem_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module brem_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [brem_pkg::QUO_W-1:0]  i_val,
    output logic                             o_done,
    output logic [brem_pkg::RMS_W-1:0]       o_root
);
    import brem_pkg::*;

    localparam int unsigned W = 2 * RMS_W;

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_v;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;

    logic [W-1:0] trial;
    logic         take;

    assign trial = r_res + r_bit;
    assign take  = r_v >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= W'(i_val);
            r_res <= '0;
            r_bit <= W'(1) << (W - 2);
        end else if (r_busy) begin
            if (take) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[RMS_W-1:0];

endmodule
`default_nettype wire

[sv/brem_store.sv]
// Per-band energy memory with valid bits and the smoothing multiply-add.
`default_nettype none
module brem_store #(
    parameter int unsigned NUM_BANDS = brem_pkg::NUM_BANDS_DEF,
    parameter int unsigned AW        = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire brem_pkg::t_store_ctl          i_ctl,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic [brem_pkg::RMS_W-1:0]    i_rms,
    output logic [brem_pkg::ENERGY_W-1:0]      o_energy
);
    import brem_pkg::*;

    localparam int unsigned POLD_W = ENERGY_W + COEF_W;
    localparam int unsigned PNEW_W = RMS_W + COEF_W;
    localparam int unsigned ACC_W  = POLD_W + 1;

    logic [ENERGY_W-1:0]  r_mem [NUM_BANDS];
    logic [NUM_BANDS-1:0] r_valid;
    logic [ENERGY_W-1:0]  r_rdata;
    logic                 r_rvalid;
    logic [POLD_W-1:0]    r_p_old;
    logic [PNEW_W-1:0]    r_p_new;

    logic [ENERGY_W-1:0]     old_energy;
    logic [ACC_W-1:0]        acc;
    logic [ACC_W-COEF_W-1:0] scaled;

    // An entry never written since reset reads as zero energy.
    assign old_energy = r_rvalid ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_ctl.wr) begin
            r_mem[i_addr] <= o_energy;
        end
        if (i_ctl.mul) begin
            r_p_old <= old_energy * C_OLD;
            r_p_new <= i_rms * C_NEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.rd) begin
                r_rvalid <= r_valid[i_addr];
            end
            if (i_ctl.wr) begin
                r_valid[i_addr] <= 1'b1;
            end
        end
    end

    assign acc    = ACC_W'(r_p_old) + ACC_W'(r_p_new);
    assign scaled = acc[ACC_W-1:COEF_W];
    assign o_energy = (scaled > (ACC_W-COEF_W)'({ENERGY_W{1'b1}})) ?
                      {ENERGY_W{1'b1}} : scaled[ENERGY_W-1:0];

endmodule
`default_nettype wire

[sv/band_rms_energy_meter.sv]
// Top level of the band RMS energy meter: APB register, sample sequencer and result beat.
//
// Input beats carry one signed Q1.15 sample and a frame_end flag; output beats
// report one band: its index, smoothed RMS energy and a last_band flag.
// samples_per_band is written over APB at address 0; the user must write it only
// while the block is idle, as the block itself does not enforce this. A sample
// that completes no band is squared into a register, then added to the band sum.
// A completed band reads its entry in the energy memory, runs a divide by the
// band length and a square root, then smooths and writes back that entry before
// its beat is offered. On an early frame end each remaining band follows in
// turn; a band with an empty sum skips the divide and square root.
// Input ready is high only while no sample or band is in progress.
// Reset clears the counters, the band sum and the valid bits of the energy
// memory, so every band starts from zero energy with no clearing pass.
// A stalled output holds its beat; the sequencer goes on with the next band but
// waits in its emit state until that beat has been taken.
`default_nettype none
module band_rms_energy_meter #(
    parameter int unsigned NUM_BANDS = brem_pkg::NUM_BANDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire brem_pkg::t_in_beat             i_in_beat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output brem_pkg::t_out_beat                 o_out_beat,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [brem_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import brem_pkg::*;

    localparam int unsigned AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int unsigned BW = $clog2(NUM_BANDS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_START,
        S_DIV,
        S_SQRT,
        S_MUL,
        S_EMIT,
        S_NEXT
    } t_state;

    t_state            r_state;
    logic [SPB_W-1:0]  r_spb;
    logic [SQ_W-1:0]   r_sq;
    logic              r_fend;
    logic [SUM_W-1:0]  r_sum;
    logic [SPB_W-1:0]  r_count;
    logic [BW-1:0]     r_band;
    logic [RMS_W-1:0]  r_rms;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [SPB_W-1:0]    band_len;
    logic [SAMPLE_W:0]   ext;
    logic [SAMPLE_W:0]   mag;
    logic [2*SAMPLE_W+1:0] sq_full;
    logic [SUM_W-1:0]    sum_acc;
    logic [SPB_W-1:0]    cnt_inc;
    logic                band_live;
    logic                more_bands;
    logic                out_free;
    logic                cfg_wr;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    quot;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [RMS_W-1:0]    root;
    t_store_ctl          store_ctl;
    logic [ENERGY_W-1:0] energy;

    // APB register: written on the access cycle, reads back the stored value.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SPB);
    assign prdata = (paddr[2] == REG_SPB) ? 32'(r_spb) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb <= SPB_RESET;
        end else if (cfg_wr) begin
            r_spb <= pwdata[SPB_W-1:0];
        end
    end

    always_comb begin
        if (r_spb == '0) begin
            band_len = SPB_W'(1);
        end else if (r_spb > SPB_MAX) begin
            band_len = SPB_MAX;
        end else begin
            band_len = r_spb;
        end
    end

    assign ext     = {i_in_beat.sample[SAMPLE_W-1], i_in_beat.sample};
    assign mag     = i_in_beat.sample[SAMPLE_W-1] ? (~ext + (SAMPLE_W+1)'(1)) : ext;
    assign sq_full = mag * mag;

    assign sum_acc    = r_sum + SUM_W'(r_sq);
    assign cnt_inc    = r_count + SPB_W'(1);
    assign band_live  = r_band < BW'(NUM_BANDS);
    assign more_bands = (r_band + BW'(1)) < BW'(NUM_BANDS);
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_in_ready = (r_state == S_IDLE);
    assign div_start  = (r_state == S_START) && (r_sum != '0);
    assign sqrt_start = (r_state == S_DIV) && div_done;

    assign store_ctl.rd  = (r_state == S_START);
    assign store_ctl.mul = (r_state == S_MUL);
    assign store_ctl.wr  = (r_state == S_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fend      <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_band      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The emit state loads the next beat itself when the slot frees up.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sq    <= sq_full[SQ_W-1:0];
                        r_fend  <= i_in_beat.frame_end;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (band_live) begin
                        r_sum   <= sum_acc;
                        r_count <= cnt_inc;
                        // A partial band at frame end is still divided by the full length.
                        if (cnt_inc >= band_len || r_fend) begin
                            r_state <= S_START;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_fend) begin
                            r_band  <= '0;
                            r_count <= '0;
                            r_sum   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_START: begin
                    if (r_sum == '0) begin
                        r_rms   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_rms   <= root;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.band_index  <= 5'(r_band);
                        r_out.band_energy <= energy;
                        r_out.last_band   <= (r_band == BW'(NUM_BANDS - 1));
                        r_out_valid       <= 1'b1;
                        r_state           <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_sum   <= '0;
                    r_count <= '0;
                    if (r_fend && more_bands) begin
                        r_band  <= r_band + BW'(1);
                        r_state <= S_START;
                    end else if (r_fend) begin
                        r_band  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_band  <= r_band + BW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    brem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (band_len),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    brem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (quot),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    brem_store #(
        .NUM_BANDS (NUM_BANDS),
        .AW        (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (store_ctl),
        .i_addr   (r_band[AW-1:0]),
        .i_rms    (r_rms),
        .o_energy (energy)
    );

endmodule
`default_nettype wire
